// ----- design/assert_macros.svh -----
// Concurrent assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- design/ctg_pkg.sv -----
package ctg_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int FractionBitsDefault = 16;
	localparam int AtanLen = 30;
	localparam int QueueDepth = 4;
	localparam logic [63:0] TurnScale = 64'd683565276;
	localparam logic [63:0] GainQ30 = 64'd652032874;

	localparam logic [2:0] RegRadius = 3'd0;
	localparam logic [2:0] RegRate = 3'd1;
	localparam logic [2:0] RegDelay = 3'd2;
	localparam logic [2:0] RegOriginX = 3'd3;
	localparam logic [2:0] RegOriginY = 3'd4;
	localparam logic [2:0] RegOriginZ = 3'd5;

	typedef struct packed {
		logic holding;
		logic flip;
		logic signed [31:0] z;
	} phase_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- design/ctg_front.sv -----
module ctg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] sample_time,
	input  logic signed [31:0] angular_rate,
	input  logic [31:0] delay_before_start,
	output logic push,
	output ctg_pkg::phase_t push_data,
	input  ctg_pkg::queue_status_t q_status
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic hold_s1, hold_s2, hold_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic [31:0] dt_s1, absw_s1;
	logic [63:0] mag_s2;
	logic [39:0] hi_s3;
	logic [29:0] lo_s3;
	ctg_pkg::phase_t ph_s4;
	logic adv;
	logic [63:0] hi_prod, lo_prod;
	logic [39:0] sum;
	logic [31:0] turns, zt;
	logic fl;

	assign adv = !(v_s4 && q_status.full);
	assign in_ready = adv;
	assign push = v_s4 && adv;
	assign push_data = ph_s4;

	assign hi_prod = {32'd0, mag_s2[63:32]} * ctg_pkg::TurnScale;
	assign lo_prod = {32'd0, mag_s2[31:0]} * ctg_pkg::TurnScale;
	assign sum = hi_s3 + {10'd0, lo_s3};

	always_comb begin
		turns = neg_s3 ? (32'd0 - sum[39:8]) : sum[39:8];
		fl = turns[31] ^ turns[30];
		zt = fl ? {~turns[31], turns[30:0]} : turns;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_s1 <= sample_time <= delay_before_start;
			dt_s1 <= sample_time - delay_before_start;
			neg_s1 <= angular_rate[31];
			absw_s1 <= angular_rate[31] ? (32'd0 - angular_rate) : angular_rate;
			mag_s2 <= {32'd0, absw_s1} * {32'd0, dt_s1};
			hold_s2 <= hold_s1;
			neg_s2 <= neg_s1;
			hi_s3 <= hi_prod[39:0];
			lo_s3 <= lo_prod[61:32];
			hold_s3 <= hold_s2;
			neg_s3 <= neg_s2;
			ph_s4.holding <= hold_s3;
			ph_s4.flip <= fl;
			ph_s4.z <= zt;
		end
	end

endmodule

// ----- design/ctg_queue.sv -----
module ctg_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ctg_pkg::phase_t push_data,
	input  logic pop,
	output ctg_pkg::phase_t pop_data,
	output ctg_pkg::queue_status_t status
);

	localparam int Aw = $clog2(ctg_pkg::QueueDepth);

	ctg_pkg::phase_t mem_q [0:ctg_pkg::QueueDepth-1];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;

	assign status.full = cnt_q == (Aw+1)'(ctg_pkg::QueueDepth);
	assign status.empty = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- design/ctg_back.sv -----
module ctg_back #(
	parameter int CORDIC_STEPS = ctg_pkg::CordicStepsDefault,
	parameter int FRACTION_BITS = ctg_pkg::FractionBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  ctg_pkg::queue_status_t q_status,
	input  ctg_pkg::phase_t pop_data,
	output logic pop,
	input  logic [30:0] circle_radius,
	input  logic signed [31:0] angular_rate,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	output logic out_valid,
	input  logic out_ready,
	output logic [287:0] out_data,
	output logic out_holding
);

	localparam int N = (CORDIC_STEPS < ctg_pkg::AtanLen) ? CORDIC_STEPS : ctg_pkg::AtanLen;
	localparam int W = FRACTION_BITS + 3;
	localparam int P = 32 + W;
	localparam logic [63:0] Gain =
		(ctg_pkg::GainQ30 + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);

	logic be;
	logic [N:0] v_s;
	logic flip_s [0:N];
	logic hold_s [0:N];
	logic signed [W-1:0] cx_s [0:N];
	logic signed [W-1:0] cy_s [0:N];
	logic signed [32:0] cz_s [0:N];
	logic signed [31:0] a1_q, a2_q, a3_q;
	logic signed [63:0] m1, m2, m3;
	logic signed [W-1:0] sn, cs;
	logic v_s1, hold_s1;
	logic signed [P-1:0] prs_s1, prc_s1, p1c_s1, p1s_s1, p2s_s1, p2c_s1, p3c_s1, p3s_s1;
	logic signed [36:0] qrs, qrc, q1c, q1s, q2s, q2c, q3c, q3s;
	logic signed [31:0] r32;

	assign be = !out_valid || out_ready;
	assign pop = be && !q_status.empty;
	assign r32 = {1'b0, circle_radius};

	assign m1 = 64'(r32) * 64'(angular_rate);
	assign m2 = 64'(a1_q) * 64'(angular_rate);
	assign m3 = 64'(a2_q) * 64'(angular_rate);

	always_ff @(posedge clk) begin
		a1_q <= ctg_pkg::sat32(m1 >>> 24);
		a2_q <= ctg_pkg::sat32(m2 >>> 24);
		a3_q <= ctg_pkg::sat32(m3 >>> 24);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (be) begin
			v_s <= {v_s[N-1:0], pop};
			v_s1 <= v_s[N];
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			cx_s[0] <= W'(Gain);
			cy_s[0] <= '0;
			cz_s[0] <= {pop_data.z[31], pop_data.z};
			flip_s[0] <= pop_data.flip;
			hold_s[0] <= pop_data.holding;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [32:0] at;
		assign at = {1'b0, ctg_pkg::atan_turns(5'(i))};
		always_ff @(posedge clk) begin
			if (be) begin
				flip_s[i+1] <= flip_s[i];
				hold_s[i+1] <= hold_s[i];
				if (!cz_s[i][32]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + at;
				end
			end
		end
	end

	assign sn = flip_s[N] ? -cy_s[N] : cy_s[N];
	assign cs = flip_s[N] ? -cx_s[N] : cx_s[N];

	always_ff @(posedge clk) begin
		if (be) begin
			hold_s1 <= hold_s[N];
			prs_s1 <= P'(r32) * P'(sn);
			prc_s1 <= P'(r32) * P'(cs);
			p1c_s1 <= P'(a1_q) * P'(cs);
			p1s_s1 <= P'(a1_q) * P'(sn);
			p2s_s1 <= P'(a2_q) * P'(sn);
			p2c_s1 <= P'(a2_q) * P'(cs);
			p3c_s1 <= P'(a3_q) * P'(cs);
			p3s_s1 <= P'(a3_q) * P'(sn);
		end
	end

	assign qrs = 37'(prs_s1 >>> FRACTION_BITS);
	assign qrc = 37'(prc_s1 >>> FRACTION_BITS);
	assign q1c = 37'(p1c_s1 >>> FRACTION_BITS);
	assign q1s = 37'(p1s_s1 >>> FRACTION_BITS);
	assign q2s = 37'(p2s_s1 >>> FRACTION_BITS);
	assign q2c = 37'(p2c_s1 >>> FRACTION_BITS);
	assign q3c = 37'(p3c_s1 >>> FRACTION_BITS);
	assign q3s = 37'(p3s_s1 >>> FRACTION_BITS);

	always_ff @(posedge clk) begin
		if (be) begin
			out_holding <= hold_s1;
			if (hold_s1) begin
				out_data <= {192'd0, 32'd0, origin_y, origin_x};
			end else begin
				out_data[31:0] <= ctg_pkg::sat32(64'(37'(origin_x) + qrs));
				out_data[63:32] <= ctg_pkg::sat32(64'(37'(origin_y) + 37'(r32) - qrc));
				out_data[95:64] <= '0;
				out_data[127:96] <= ctg_pkg::sat32(64'(q1c));
				out_data[159:128] <= ctg_pkg::sat32(64'(q1s));
				out_data[191:160] <= ctg_pkg::sat32(-64'(q2s));
				out_data[223:192] <= ctg_pkg::sat32(64'(q2c));
				out_data[255:224] <= ctg_pkg::sat32(-64'(q3c));
				out_data[287:256] <= ctg_pkg::sat32(-64'(q3s));
			end
		end
	end

endmodule

// ----- design/circle_trajectory_generator.sv -----
// Circular setpoint generator on stream channels.
// The slave channel takes one sample time (unsigned Q16.16 seconds) per item.
// The master channel returns one item per sample: x, y, z position, x and y
// velocity, acceleration and jerk in tdata, and the holding flag in tuser.
// The config channel writes one register per handshake; it is always ready,
// and it must only be used while no item is in flight.
// One item is accepted per cycle while the output is taken. Each item passes
// four front stages that form the phase, then the queue, the CORDIC start
// stage and the CORDIC stages, then the product stage and the sum and clamp
// stage that also holds the result.
// A four-entry queue sits between the phase front end and the CORDIC back end.
// When the receiver stalls, the back end freezes, the queue fills and then
// the front end drops tready.
// Reset empties all stages and the queue and loads the register defaults.
// The z position always follows origin_z.
`include "assert_macros.svh"
module circle_trajectory_generator #(
	parameter int CORDIC_STEPS = ctg_pkg::CordicStepsDefault,
	parameter int FRACTION_BITS = ctg_pkg::FractionBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample_time
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// position_x, position_y, position_z, velocity_x, velocity_y,
	// acceleration_x, acceleration_y, jerk_x, jerk_y
	output logic [287:0] m_axis_tdata,
	output logic m_axis_tuser,          // holding
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic [30:0] radius_q;
	logic signed [31:0] rate_q, ox_q, oy_q, oz_q;
	logic [31:0] delay_q;
	logic push, pop;
	ctg_pkg::phase_t push_data, pop_data;
	ctg_pkg::queue_status_t q_status;
	logic [287:0] back_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 31'd65536;
			rate_q <= 32'sd16777216;
			delay_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ctg_pkg::RegRadius: radius_q <= cfg_data[30:0];
				ctg_pkg::RegRate: rate_q <= cfg_data;
				ctg_pkg::RegDelay: delay_q <= cfg_data;
				ctg_pkg::RegOriginX: ox_q <= cfg_data;
				ctg_pkg::RegOriginY: oy_q <= cfg_data;
				ctg_pkg::RegOriginZ: oz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ctg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sample_time(s_axis_tdata),
		.angular_rate(rate_q),
		.delay_before_start(delay_q),
		.push(push),
		.push_data(push_data),
		.q_status(q_status)
	);

	ctg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.status(q_status)
	);

	ctg_back #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.pop_data(pop_data),
		.pop(pop),
		.circle_radius(radius_q),
		.angular_rate(rate_q),
		.origin_x(ox_q),
		.origin_y(oy_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(back_data),
		.out_holding(m_axis_tuser)
	);

	always_comb begin
		m_axis_tdata = back_data;
		m_axis_tdata[95:64] = oz_q;
	end

	`ASSERT_NEVER(a_queue_full_empty, clk, arst_n, q_status.full && q_status.empty, "queue full and empty")
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && q_status.full && !pop, "push into full queue")
	`ASSERT_AT(a_hold_zero, clk, arst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[287:96] == '0), "derivatives not zero while holding")

endmodule

// ----- bench/tb_circle_trajectory_generator.sv -----
`timescale 1ns / 100ps
module tb_circle_trajectory_generator;

	localparam int Steps = ctg_pkg::CordicStepsDefault;
	localparam int Frac = ctg_pkg::FractionBitsDefault;
	localparam int DrainCycles = 48;
	localparam longint CycleLimit = 400000;
	localparam logic [2:0] RegUnused = 3'd6;
	localparam logic [2:0] RegBeyond = 3'd7;

	typedef struct {
		logic [8:0][31:0] field;
		logic holding;
	} setpoint_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [287:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	logic [30:0] radius_q;
	logic signed [31:0] rate_q;
	logic [31:0] delay_q;
	logic signed [31:0] org_x, org_y, org_z;

	setpoint_t pending_setpoints[$];
	int mismatches;
	int sent_count;
	longint cycle_count;
	bit no_idle;
	bit hold_request;

	const longint atan_tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

	circle_trajectory_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic setpoint_t predict_setpoint(logic [31:0] t);
		setpoint_t sp;
		logic [63:0] dt, abs_rate, mag, turns;
		longint w, r, z, x, y, dx, dy, s, c, a1, a2, a3;
		bit neg, flip;
		sp.field[2] = org_z;
		if (t <= delay_q) begin
			sp.field[0] = org_x;
			sp.field[1] = org_y;
			for (int k = 3; k < 9; k++) sp.field[k] = '0;
			sp.holding = 1'b1;
			return sp;
		end
		dt = 64'(t) - 64'(delay_q);
		w = rate_q;
		r = longint'(radius_q);
		neg = w < 0;
		abs_rate = neg ? 64'(-w) : 64'(w);
		mag = abs_rate * dt;
		turns = (((mag >> 32) * ctg_pkg::TurnScale
			+ (((mag & 64'hFFFFFFFF) * ctg_pkg::TurnScale) >> 32)) >> 8) & 64'hFFFFFFFF;
		if (neg) begin
			turns = (64'h100000000 - turns) & 64'hFFFFFFFF;
		end
		z = longint'(signed'(turns[31:0]));
		flip = 1'b0;
		if (z >= 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1'b1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1'b1;
		end
		x = (longint'(ctg_pkg::GainQ30) + (64'sd1 << (29 - Frac))) >>> (30 - Frac);
		y = 0;
		for (int i = 0; i < Steps && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
		a1 = longint'(signed'(clamp32((r * w) >>> 24)));
		a2 = longint'(signed'(clamp32((a1 * w) >>> 24)));
		a3 = longint'(signed'(clamp32((a2 * w) >>> 24)));
		sp.field[0] = clamp32(longint'(org_x) + ((r * s) >>> Frac));
		sp.field[1] = clamp32(longint'(org_y) + r - ((r * c) >>> Frac));
		sp.field[3] = clamp32((a1 * c) >>> Frac);
		sp.field[4] = clamp32((a1 * s) >>> Frac);
		sp.field[5] = clamp32(-((a2 * s) >>> Frac));
		sp.field[6] = clamp32((a2 * c) >>> Frac);
		sp.field[7] = clamp32(-((a3 * c) >>> Frac));
		sp.field[8] = clamp32(-((a3 * s) >>> Frac));
		sp.holding = 1'b0;
		return sp;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ctg_pkg::RegRadius: radius_q = val[30:0];
			ctg_pkg::RegRate: rate_q = val;
			ctg_pkg::RegDelay: delay_q = val;
			ctg_pkg::RegOriginX: org_x = val;
			ctg_pkg::RegOriginY: org_y = val;
			ctg_pkg::RegOriginZ: org_z = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [31:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= t;
		do @(posedge clk); while (!s_axis_tready);
		pending_setpoints.push_back(predict_setpoint(t));
		sent_count++;
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (pending_setpoints.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_all(logic [31:0] r, logic [31:0] w, logic [31:0] d,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		drain_pipeline();
		write_reg(ctg_pkg::RegRadius, r);
		write_reg(ctg_pkg::RegRate, w);
		write_reg(ctg_pkg::RegDelay, d);
		write_reg(ctg_pkg::RegOriginX, x);
		write_reg(ctg_pkg::RegOriginY, y);
		write_reg(ctg_pkg::RegOriginZ, z);
	endtask

	task automatic test_reset_defaults();
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'h0001_0000);
		send_sample(32'hffff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h0006_487f);
	endtask

	task automatic test_holding_edge();
		write_all(32'h0002_0000, 32'hff00_0000, 32'h0010_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h1234_5678);
		send_sample(32'h000f_ffff);
		send_sample(32'h0010_0000);
		send_sample(32'h0010_0001);
		send_sample(32'h0000_0000);
		send_sample(32'hffff_ffff);
		write_all(32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
		send_sample(32'hffff_ffff);
		send_sample(32'h0);
	endtask

	task automatic test_extremes();
		write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000);
		send_sample(32'h1);
		send_sample(32'hffff_ffff);
		send_sample(32'h0123_4567);
		write_all(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff);
		send_sample(32'h1);
		send_sample(32'hffff_ffff);
		send_sample(32'h0765_4321);
		write_all(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_sample(32'h0001_0000);
		drain_pipeline();
		write_reg(RegUnused, 32'hdead_beef);
		write_reg(RegBeyond, 32'h1234_5678);
		send_sample(32'h0002_0000);
	endtask

	task automatic test_random_phases();
		logic [31:0] r, w, d;
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: r = $urandom_range(0, 32'h000a_0000);
				1: r = $urandom;
				default: r = $urandom_range(0, 32'h0100_0000);
			endcase
			w = (p % 3 == 0) ? $urandom : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			d = (p % 2 == 0) ? $urandom_range(0, 32'h0010_0000) : $urandom;
			write_all(r, w, d, $urandom, $urandom, $urandom);
			no_idle = (p == 5);
			for (int n = 0; n < 125; n++) begin
				case ($urandom_range(0, 3))
					0: send_sample($urandom);
					1: send_sample(d + $urandom_range(0, 32'h0040_0000));
					2: send_sample(d + $urandom_range(0, 8) - 4);
					default: send_sample($urandom_range(0, 32'h0008_0000));
				endcase
			end
			no_idle = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		drain_pipeline();
		hold_request = 1'b1;
		no_idle = 1'b1;
		for (int n = 0; n < 60; n++) send_sample($urandom);
		no_idle = 1'b0;
	endtask

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				gap = 300;
				hold_request = 1'b0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 18);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		setpoint_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_setpoints.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected item: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
				end
			end else begin
				want = pending_setpoints.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (m_axis_tdata[32*k +: 32] !== want.field[k]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Field %0d mismatch: expected %h, got %h", k,
								want.field[k], m_axis_tdata[32*k +: 32]);
						end
					end
				end
				if (m_axis_tuser !== want.holding) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Holding mismatch: expected %b, got %b", want.holding,
							m_axis_tuser);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL circle_trajectory_generator");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		sent_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		radius_q = 31'd65536;
		rate_q = 32'sd16777216;
		delay_q = '0;
		org_x = '0;
		org_y = '0;
		org_z = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_holding_edge();
		test_extremes();
		test_random_phases();
		test_backpressure();
		drain_pipeline();
		if (mismatches == 0) begin
			$display("PASS circle_trajectory_generator");
		end else begin
			$display("FAIL circle_trajectory_generator");
		end
		$finish;
	end

endmodule
